// ----- design/atrfc_pkg.sv -----
// Shared class codes, field masks and stage types for the relocation field codec.
package atrfc_pkg;

	// Relocation format classes
	localparam logic [3:0] CLS_NONE   = 4'd0;
	localparam logic [3:0] CLS_DATA32 = 4'd1;
	localparam logic [3:0] CLS_THM8   = 4'd2;
	localparam logic [3:0] CLS_THM11  = 4'd3;
	localparam logic [3:0] CLS_THMB21 = 4'd4;
	localparam logic [3:0] CLS_THMB25 = 4'd5;
	localparam logic [3:0] CLS_ARMB24 = 4'd6;
	localparam logic [3:0] CLS_ARMMOV = 4'd7;
	localparam logic [3:0] CLS_PREL31 = 4'd8;
	localparam logic [3:0] CLS_THMMOV = 4'd9;

	// One-hot bit positions, one per known class
	localparam int unsigned NUM_SEL    = 9;
	localparam int unsigned SEL_DATA32 = 0;
	localparam int unsigned SEL_THM8   = 1;
	localparam int unsigned SEL_THM11  = 2;
	localparam int unsigned SEL_THMB21 = 3;
	localparam int unsigned SEL_THMB25 = 4;
	localparam int unsigned SEL_ARMB24 = 5;
	localparam int unsigned SEL_ARMMOV = 6;
	localparam int unsigned SEL_PREL31 = 7;
	localparam int unsigned SEL_THMMOV = 8;

	// Masks of the bits that stay when a field is rewritten
	localparam logic [31:0] MASK_ARMMOV  = 32'hfff0_f000;
	localparam logic [15:0] MASK_B21_H0  = 16'b1111_1011_1100_0000;
	localparam logic [15:0] MASK_B25_H0  = 16'b1111_1000_0000_0000;
	localparam logic [15:0] MASK_BR_H1   = 16'b1101_0000_0000_0000;
	localparam logic [15:0] MASK_MOV_H0  = 16'b1111_1011_1111_0000;
	localparam logic [15:0] MASK_MOV_H1  = 16'b1000_1111_0000_0000;
	localparam logic [15:0] MASK_THM8    = 16'hff00;
	localparam logic [15:0] MASK_THM11   = 16'hf800;
	localparam logic [31:0] MASK_ARMB24  = 32'hff00_0000;
	localparam logic [31:0] MASK_PREL_HI = 32'h8000_0000;
	localparam logic [31:0] MASK_PREL_LO = 32'h7fff_ffff;

	typedef logic [NUM_SEL-1:0] cls_sel_t;

	// Addend before sign extension, with the position of its sign bit
	typedef struct packed {
		logic [31:0] raw;
		logic [4:0]  sign_pos;
	} addend_raw_t;

	// Class code to one-hot select; unknown codes give all zeros
	function automatic cls_sel_t decode_class(input logic [3:0] cls);
		cls_sel_t sel;
		sel = '0;
		unique case (cls)
			CLS_DATA32: sel[SEL_DATA32] = 1'b1;
			CLS_THM8:   sel[SEL_THM8]   = 1'b1;
			CLS_THM11:  sel[SEL_THM11]  = 1'b1;
			CLS_THMB21: sel[SEL_THMB21] = 1'b1;
			CLS_THMB25: sel[SEL_THMB25] = 1'b1;
			CLS_ARMB24: sel[SEL_ARMB24] = 1'b1;
			CLS_ARMMOV: sel[SEL_ARMMOV] = 1'b1;
			CLS_PREL31: sel[SEL_PREL31] = 1'b1;
			CLS_THMMOV: sel[SEL_THMMOV] = 1'b1;
			default:    sel = '0;
		endcase
		return sel;
	endfunction

endpackage

// ----- design/atrfc_extract.sv -----
// Gathers the scattered immediate bits of a word into a raw addend and sign position.
module atrfc_extract (
	input  atrfc_pkg::cls_sel_t    sel,
	input  logic [31:0]            word,
	output atrfc_pkg::addend_raw_t addend_raw
);

	logic [15:0] h0;
	logic [15:0] h1;
	logic        s;
	logic        i1;
	logic        i2;

	assign h0 = word[15:0];
	assign h1 = word[31:16];
	assign s  = h0[10];
	// BL/BLX: I = NOT(J XOR S)
	assign i1 = ~(h1[13] ^ s);
	assign i2 = ~(h1[11] ^ s);

	// AND-OR select over the one-hot class
	always_comb begin
		addend_raw = '0;
		if (sel[atrfc_pkg::SEL_DATA32]) begin
			addend_raw.raw      = word;
			addend_raw.sign_pos = 5'd31;
		end
		if (sel[atrfc_pkg::SEL_THM8]) begin
			addend_raw.raw      = {23'd0, h0[7:0], 1'b0};
			addend_raw.sign_pos = 5'd8;
		end
		if (sel[atrfc_pkg::SEL_THM11]) begin
			addend_raw.raw      = {20'd0, h0[10:0], 1'b0};
			addend_raw.sign_pos = 5'd11;
		end
		if (sel[atrfc_pkg::SEL_THMB21]) begin
			addend_raw.raw      = {11'd0, h0[10], h1[11], h1[13], h0[5:0], h1[10:0], 1'b0};
			addend_raw.sign_pos = 5'd20;
		end
		if (sel[atrfc_pkg::SEL_THMB25]) begin
			addend_raw.raw      = {7'd0, s, i1, i2, h0[9:0], h1[10:0], 1'b0};
			addend_raw.sign_pos = 5'd24;
		end
		if (sel[atrfc_pkg::SEL_ARMB24]) begin
			addend_raw.raw      = {6'd0, word[23:0], 2'b00};
			addend_raw.sign_pos = 5'd25;
		end
		if (sel[atrfc_pkg::SEL_ARMMOV]) begin
			addend_raw.raw      = {16'd0, word[19:16], word[11:0]};
			addend_raw.sign_pos = 5'd15;
		end
		if (sel[atrfc_pkg::SEL_PREL31]) begin
			addend_raw.raw      = {1'b0, word[30:0]};
			addend_raw.sign_pos = 5'd30;
		end
		if (sel[atrfc_pkg::SEL_THMMOV]) begin
			addend_raw.raw      = {16'd0, h0[3:0], h0[10], h1[14:12], h1[7:0]};
			addend_raw.sign_pos = 5'd15;
		end
	end

endmodule

// ----- design/atrfc_insert.sv -----
// Writes the value's bits into the immediate fields of the word for each class.
module atrfc_insert (
	input  atrfc_pkg::cls_sel_t sel,
	input  logic [31:0]         word,
	input  logic [31:0]         value,
	output logic [31:0]         patched
);

	logic [15:0] h0;
	logic [15:0] h1;
	logic        s;
	logic        j1;
	logic        j2;

	assign h0 = word[15:0];
	assign h1 = word[31:16];
	assign s  = value[24];
	// BL/BLX: J = NOT(I) XOR S
	assign j1 = ~value[23] ^ s;
	assign j2 = ~value[22] ^ s;

	// Unknown class passes the word through
	always_comb begin
		patched = word;
		if (sel[atrfc_pkg::SEL_DATA32])
			patched = value;
		if (sel[atrfc_pkg::SEL_THM8])
			patched = {h1, (h0 & atrfc_pkg::MASK_THM8) | {8'd0, value[8:1]}};
		if (sel[atrfc_pkg::SEL_THM11])
			patched = {h1, (h0 & atrfc_pkg::MASK_THM11) | {5'd0, value[11:1]}};
		if (sel[atrfc_pkg::SEL_THMB21])
			patched = {(h1 & atrfc_pkg::MASK_BR_H1)
					| {2'b00, value[18], 1'b0, value[19], value[11:1]},
				(h0 & atrfc_pkg::MASK_B21_H0)
					| {5'd0, value[20], 4'd0, value[17:12]}};
		if (sel[atrfc_pkg::SEL_THMB25])
			patched = {(h1 & atrfc_pkg::MASK_BR_H1)
					| {2'b00, j1, 1'b0, j2, value[11:1]},
				(h0 & atrfc_pkg::MASK_B25_H0) | {5'd0, s, value[21:12]}};
		if (sel[atrfc_pkg::SEL_ARMB24])
			patched = (word & atrfc_pkg::MASK_ARMB24) | {8'd0, value[25:2]};
		if (sel[atrfc_pkg::SEL_ARMMOV])
			patched = (word & atrfc_pkg::MASK_ARMMOV)
				| {12'd0, value[15:12], 4'd0, value[11:0]};
		if (sel[atrfc_pkg::SEL_PREL31])
			patched = (word & atrfc_pkg::MASK_PREL_HI) | (value & atrfc_pkg::MASK_PREL_LO);
		if (sel[atrfc_pkg::SEL_THMMOV])
			patched = {(h1 & atrfc_pkg::MASK_MOV_H1) | {1'b0, value[10:8], 4'd0, value[7:0]},
				(h0 & atrfc_pkg::MASK_MOV_H0) | {5'd0, value[11], 6'd0, value[15:12]}};
	end

endmodule

// ----- design/atrfc_sext.sv -----
// Sign-extends a raw addend from the given sign bit position.
module atrfc_sext (
	input  atrfc_pkg::addend_raw_t addend_raw,
	output logic [31:0]            addend
);

	logic [31:0] ext_mask;

	// Ones above the sign bit; empty when the sign bit is bit 31
	assign ext_mask = ~((32'd2 << addend_raw.sign_pos) - 32'd1);
	assign addend   = addend_raw.raw[addend_raw.sign_pos] ?
		(addend_raw.raw | ext_mask) : addend_raw.raw;

endmodule

// ----- design/arm_thumb_reloc_field_codec_core.sv -----
// Top level of the ARM/Thumb relocation immediate-field codec pipeline.
//
//  Channel   Handshake                    Payload
//  item      item_valid / item_ready      format_class, insn_word, insert_value
//  result    result_valid / result_ready  addend, patched_word
//
// Three register stages: class decode, field extract/insert, sign extension.
// One item per cycle unless the result side stalls; an item passes the stage 1, 2
// and 3 registers in that order before its result is valid.
// arst_n clears the stage valid bits only; payload registers are not reset.
// A stall at the result side holds every full stage; a stage takes new data
// whenever it is empty or the stage after it moves.
module arm_thumb_reloc_field_codec_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_ready,
	input  logic [3:0]         format_class,
	input  logic [31:0]        insn_word,
	input  logic signed [31:0] insert_value,
	output logic               result_valid,
	input  logic               result_ready,
	output logic signed [31:0] addend,
	output logic [31:0]        patched_word
);

	logic                   valid_s1;
	logic                   valid_s2;
	logic                   valid_s3;
	logic                   en_s1;
	logic                   en_s2;
	logic                   en_s3;

	atrfc_pkg::cls_sel_t    sel_s1;
	logic [31:0]            word_s1;
	logic [31:0]            value_s1;

	atrfc_pkg::addend_raw_t raw_comb;
	logic [31:0]            patched_comb;
	atrfc_pkg::addend_raw_t raw_s2;
	logic [31:0]            patched_s2;

	logic [31:0]            addend_comb;
	logic [31:0]            addend_s3;
	logic [31:0]            patched_s3;

	// Stall chain: a stage loads when empty or when its successor loads
	assign en_s3      = !valid_s3 || result_ready;
	assign en_s2      = !valid_s2 || en_s3;
	assign en_s1      = !valid_s1 || en_s2;
	assign item_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (en_s1)
				valid_s1 <= item_valid;
			if (en_s2)
				valid_s2 <= valid_s1;
			if (en_s3)
				valid_s3 <= valid_s2;
		end
	end

	// Stage 1: decode class to one-hot
	always_ff @(posedge clk) begin
		if (en_s1 && item_valid) begin
			sel_s1   <= atrfc_pkg::decode_class(format_class);
			word_s1  <= insn_word;
			value_s1 <= insert_value;
		end
	end

	// Stage 2: gather addend bits and rewrite fields
	atrfc_extract u_extract (
		.sel        (sel_s1),
		.word       (word_s1),
		.addend_raw (raw_comb)
	);

	atrfc_insert u_insert (
		.sel     (sel_s1),
		.word    (word_s1),
		.value   (value_s1),
		.patched (patched_comb)
	);

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			raw_s2     <= raw_comb;
			patched_s2 <= patched_comb;
		end
	end

	// Stage 3: sign extension and output register
	atrfc_sext u_sext (
		.addend_raw (raw_s2),
		.addend     (addend_comb)
	);

	always_ff @(posedge clk) begin
		if (en_s3 && valid_s2) begin
			addend_s3  <= addend_comb;
			patched_s3 <= patched_s2;
		end
	end

	assign result_valid = valid_s3;
	assign addend       = addend_s3;
	assign patched_word = patched_s3;

endmodule

// ----- dv/arm_thumb_reloc_field_codec_core_tb.sv -----
// Self-checking testbench for the ARM/Thumb relocation field codec core.
`timescale 1ns / 100ps

module arm_thumb_reloc_field_codec_core_tb;

	localparam logic [3:0] CLS_FIRST_UNUSED = atrfc_pkg::CLS_THMMOV + 4'd1;
	localparam logic [3:0] CLS_LAST_UNUSED  = 4'hf;
	localparam int unsigned RANDOM_ITEMS   = 550;
	localparam int unsigned CYCLE_LIMIT    = 200000;
	localparam int unsigned DRAIN_CYCLES   = 20;
	localparam int unsigned HOLD_LENGTH    = 48;

	typedef struct {
		logic [3:0]  cls;
		logic [31:0] word;
		logic [31:0] value;
	} reloc_item_t;

	typedef struct {
		logic [31:0] addend;
		logic [31:0] patched;
	} reloc_result_t;

	typedef enum logic [1:0] {RX_STREAM, RX_RANDOM, RX_SPARSE} rx_mode_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               item_valid = 1'b0;
	logic               item_ready;
	logic [3:0]         format_class = '0;
	logic [31:0]        insn_word = '0;
	logic signed [31:0] insert_value = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic signed [31:0] addend;
	logic [31:0]        patched_word;

	reloc_item_t   pending_items[$];
	reloc_result_t expected_results[$];

	int unsigned error_count = 0;
	int unsigned items_accepted = 0;
	int unsigned results_checked = 0;
	int unsigned class_hits[16];
	bit          item_taken = 1'b0;

	// sender pacing
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;

	// receiver pacing
	int unsigned rx_cycle = 0;
	int unsigned hold_cycles = 0;
	int unsigned holds_done = 0;
	rx_mode_t    rx_mode = RX_STREAM;

	arm_thumb_reloc_field_codec_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.format_class (format_class),
		.insn_word    (insn_word),
		.insert_value (insert_value),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.addend       (addend),
		.patched_word (patched_word)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Keep the low 'bits' bits of x and sign-extend them to 32 bits
	function automatic logic [31:0] sext_low(input logic [31:0] x, input int unsigned bits);
		logic [31:0] keep;
		logic [31:0] sign_bit;
		keep = (bits >= 32) ? 32'hffff_ffff : ((32'd1 << bits) - 32'd1);
		sign_bit = 32'd1 << (bits - 1);
		return ((x & keep) ^ sign_bit) - sign_bit;
	endfunction

	// Addend extraction and immediate insertion for one relocation word
	function automatic reloc_result_t decode_and_patch(input logic [3:0] cls,
			input logic [31:0] w, input logic [31:0] v);
		reloc_result_t r;
		logic [15:0] h0;
		logic [15:0] h1;
		logic [31:0] raw;
		logic        s, j1, j2, i1, i2;
		h0 = w[15:0];
		h1 = w[31:16];
		r.addend = '0;
		r.patched = w;
		case (cls)
			atrfc_pkg::CLS_DATA32: begin
				r.addend = w;
				r.patched = v;
			end
			atrfc_pkg::CLS_THM8: begin
				r.addend = sext_low({16'b0, h0}, 8) << 1;
				r.patched = {h1, (h0 & atrfc_pkg::MASK_THM8) | {8'b0, v[8:1]}};
			end
			atrfc_pkg::CLS_THM11: begin
				r.addend = sext_low({16'b0, h0}, 11) << 1;
				r.patched = {h1, (h0 & atrfc_pkg::MASK_THM11) | {5'b0, v[11:1]}};
			end
			atrfc_pkg::CLS_THMB21: begin
				raw = {11'b0, h0[10], h1[11], h1[13], h0[5:0], h1[10:0], 1'b0};
				r.addend = sext_low(raw, 21);
				r.patched = {(h1 & atrfc_pkg::MASK_BR_H1)
						| {2'b0, v[18], 1'b0, v[19], v[11:1]},
					(h0 & atrfc_pkg::MASK_B21_H0) | {5'b0, v[20], 4'b0, v[17:12]}};
			end
			atrfc_pkg::CLS_THMB25: begin
				// I1/I2 are recovered from J1/J2 and S, and encoded back the same way
				s = h0[10];
				i1 = ~(h1[13] ^ s);
				i2 = ~(h1[11] ^ s);
				raw = {7'b0, s, i1, i2, h0[9:0], h1[10:0], 1'b0};
				r.addend = sext_low(raw, 25);
				s = v[24];
				j1 = ~v[23] ^ s;
				j2 = ~v[22] ^ s;
				r.patched = {(h1 & atrfc_pkg::MASK_BR_H1) | {2'b0, j1, 1'b0, j2, v[11:1]},
					(h0 & atrfc_pkg::MASK_B25_H0) | {5'b0, s, v[21:12]}};
			end
			atrfc_pkg::CLS_ARMB24: begin
				r.addend = sext_low(w, 24) << 2;
				r.patched = (w & atrfc_pkg::MASK_ARMB24) | {8'b0, v[25:2]};
			end
			atrfc_pkg::CLS_ARMMOV: begin
				r.addend = sext_low({16'b0, w[19:16], w[11:0]}, 16);
				r.patched = (w & atrfc_pkg::MASK_ARMMOV)
					| {12'b0, v[15:12], 4'b0, v[11:0]};
			end
			atrfc_pkg::CLS_PREL31: begin
				r.addend = sext_low(w, 31);
				r.patched = (w & atrfc_pkg::MASK_PREL_HI) | (v & atrfc_pkg::MASK_PREL_LO);
			end
			atrfc_pkg::CLS_THMMOV: begin
				raw = {16'b0, h0[3:0], h0[10], h1[14:12], h1[7:0]};
				r.addend = sext_low(raw, 16);
				r.patched = {(h1 & atrfc_pkg::MASK_MOV_H1) | {1'b0, v[10:8], 4'b0, v[7:0]},
					(h0 & atrfc_pkg::MASK_MOV_H0) | {5'b0, v[11], 6'b0, v[15:12]}};
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	function automatic void queue_item(input logic [3:0] cls, input logic [31:0] w,
			input logic [31:0] v);
		reloc_item_t it;
		it.cls = cls;
		it.word = w;
		it.value = v;
		pending_items.push_back(it);
	endfunction

	// Sender: bursts of items with gaps between them, inputs change on the falling edge
	always @(negedge clk) begin
		reloc_item_t nxt;
		if (arst_n && (!item_valid || item_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				item_valid <= 1'b0;
			end else if (pending_items.size() > 0) begin
				nxt = pending_items.pop_front();
				format_class <= nxt.cls;
				insn_word <= nxt.word;
				insert_value <= nxt.value;
				item_valid <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					// no gaps while the receiver is held off, so the pipe backs up
					if (hold_cycles == 0 && $urandom_range(0, 2) != 0)
						gap_left = $urandom_range(1, 7);
				end
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall pattern is re-picked at random periodically, plus two long hold-offs
	always @(negedge clk) begin
		if (arst_n) begin
			rx_cycle++;
			if (hold_cycles == 0 && ((holds_done == 0 && results_checked >= 100) ||
					(holds_done == 1 && results_checked >= 350))) begin
				hold_cycles = HOLD_LENGTH;
				holds_done++;
			end
			if (rx_cycle % 40 == 0)
				rx_mode = rx_mode_t'($urandom_range(0, 2));
			if (hold_cycles > 0) begin
				hold_cycles--;
				result_ready <= 1'b0;
			end else begin
				case (rx_mode)
					RX_STREAM: result_ready <= 1'b1;
					RX_RANDOM: result_ready <= ($urandom_range(0, 1) == 1);
					default:   result_ready <= ($urandom_range(0, 3) == 0);
				endcase
			end
		end
	end

	// Predict on each accepted item, check each accepted result
	always @(posedge clk) begin
		reloc_result_t want;
		item_taken = arst_n && item_valid && item_ready;
		if (item_taken) begin
			expected_results.push_back(decode_and_patch(format_class, insn_word, insert_value));
			class_hits[format_class]++;
			items_accepted++;
		end
		if (arst_n && result_valid && result_ready) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result addend=%h patched_word=%h",
					$time, addend, patched_word);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				if (addend !== want.addend) begin
					$display("%0t: addend mismatch: expected %h, actual %h",
						$time, want.addend, addend);
					error_count++;
				end
				if (patched_word !== want.patched) begin
					$display("%0t: patched_word mismatch: expected %h, actual %h",
						$time, want.patched, patched_word);
					error_count++;
				end
			end
			results_checked++;
		end
	end

	initial begin
		int unsigned c;
		int unsigned n;
		int unsigned wait_cycles;
		int unsigned classes_seen;
		logic [3:0]  cls;
		logic [31:0] v;

		// Directed: every class with all-ones word / zero value and the reverse
		for (c = atrfc_pkg::CLS_NONE; c <= atrfc_pkg::CLS_THMMOV; c++) begin
			queue_item(c[3:0], 32'hffff_ffff, 32'h0000_0000);
			queue_item(c[3:0], 32'h0000_0000, 32'hffff_ffff);
		end
		// unused class codes act as pass-through
		queue_item(CLS_FIRST_UNUSED, $urandom, $urandom);
		queue_item(CLS_LAST_UNUSED, $urandom, $urandom);
		// BL/BLX with S set and J bits clear, selector bit kept; out-of-range value
		queue_item(atrfc_pkg::CLS_THMB25, 32'h0000_f400, 32'h0100_0000);
		queue_item(atrfc_pkg::CLS_THMB25, 32'h1000_f000, 32'h0200_0001);
		// data extremes
		queue_item(atrfc_pkg::CLS_DATA32, 32'h8000_0000, 32'h7fff_ffff);

		// Random: mostly known classes, some unused codes, some small values
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if ($urandom_range(0, 11) == 0)
				cls = 4'($urandom_range(CLS_FIRST_UNUSED, CLS_LAST_UNUSED));
			else
				cls = 4'($urandom_range(atrfc_pkg::CLS_NONE, atrfc_pkg::CLS_THMMOV));
			if ($urandom_range(0, 3) == 0)
				v = $urandom_range(0, 4095) - 2048;
			else
				v = $urandom;
			queue_item(cls, $urandom, v);
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Run until every item is sent and every result is back
		wait_cycles = 0;
		while ((pending_items.size() != 0 || item_valid || expected_results.size() != 0)
				&& wait_cycles < CYCLE_LIMIT) begin
			@(negedge clk);
			wait_cycles++;
		end
		if (wait_cycles >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding",
				$time, expected_results.size());
			error_count++;
		end else begin
			repeat (DRAIN_CYCLES) @(negedge clk);
		end

		classes_seen = 0;
		for (c = 0; c < 16; c++)
			if (class_hits[c] != 0)
				classes_seen++;
		$display("Run covered %0d items and %0d results over %0d of 16 class codes,",
			items_accepted, results_checked, classes_seen);
		$display("with %0d long receiver hold-offs and %0d errors.", holds_done, error_count);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
